[rtl/wbps_pkg.sv]
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int IDX_W  = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int ADDR_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_HIGH = 3'd1,
    REG_WILD     = 3'd2,
    REG_LEN      = 3'd3,
    REG_OCC      = 3'd4,
    REG_BASE     = 3'd5,
    REG_OFFSET   = 3'd6
  } cfg_reg_t;

  // Pattern setup shared by every cell of the window
  typedef struct packed {
    logic [8*MAX_PATTERN_BYTES-1:0] pattern;    // byte i at bits 8i+7..8i
    logic [2*MAX_PATTERN_BYTES-1:0] wildcards;  // 2i: high nibble, 2i+1: low
    logic [LEN_W-1:0]               len;        // clamped to MAX_PATTERN_BYTES
  } pat_cfg_t;

endpackage

[rtl/wbps_cell.sv]
// One window cell: holds a stream byte and compares it to its aligned pattern byte.
module wbps_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [7:0]                byte_in,
  input  logic [wbps_pkg::IDX_W-1:0] cell_idx,
  input  wbps_pkg::pat_cfg_t        cfg,
  output logic [7:0]                byte_out,
  output logic                      hit
);
  import wbps_pkg::*;

  logic [7:0]       byte_r;
  logic [IDX_W-1:0] pat_idx;
  logic [7:0]       pat_byte;
  logic             hi_wild;
  logic             lo_wild;
  logic             in_use;

  // Shift register tap
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // Cell k (0 = newest) lines up with pattern byte len-1-k
  assign in_use   = {1'b0, cell_idx} < cfg.len;
  assign pat_idx  = IDX_W'(cfg.len - LEN_W'(1) - {1'b0, cell_idx});
  assign pat_byte = cfg.pattern[{pat_idx, 3'b000} +: 8];
  assign hi_wild  = cfg.wildcards[{pat_idx, 1'b0}];
  assign lo_wild  = cfg.wildcards[{pat_idx, 1'b1}];

  always_comb begin
    hit = 1'b1;
    if (in_use) begin
      hit = (hi_wild || (byte_r[7:4] == pat_byte[7:4])) &&
            (lo_wild || (byte_r[3:0] == pat_byte[3:0]));
    end
  end

endmodule

[rtl/wildcard_byte_pattern_scanner.sv]
// Top level: streaming byte signature scanner with per-nibble wildcards.
//
// Usage: bytes of a buffer enter on the in_ channel, one per beat, with
// in_tlast on the final byte. The pattern, nibble wildcards, length, wanted
// occurrence, base address and offset are written through the cfg_ port
// while the block is idle. At most one result beat is sent per buffer on the
// out_ channel: out_tuser = 1 with the match address when the wanted
// (overlapping) occurrence completes, or out_tuser = 0 with a zero address
// on the last byte when it never did.
// Throughput is one byte per cycle while no result is held up: the window
// is a chain of 16 cells that shift on every accepted beat and compare in
// parallel. An accepted byte is registered in the cell chain and the
// evaluation register, and its result then in the output register.
// A waiting result does not stop the scan; input backs up only when a new
// result is due while the previous one is still not taken.
// Reset (rst_n low, synchronous) clears the configuration registers and the
// buffer state to zero and drops any pending result; the buffer state also
// restarts after every last byte.
module wildcard_byte_pattern_scanner (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // last_byte
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wbps_pkg::ADDR_W-1:0]       out_tdata,  // [63:0] match_address
  output logic                              out_tuser,  // [0] found
  // configuration
  input  logic                              cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wbps_pkg::*;

  // Configuration registers
  logic [63:0]     pat_low_r;
  logic [63:0]     pat_high_r;
  logic [31:0]     wild_r;
  logic [4:0]      len_r;
  logic [7:0]      occ_r;
  logic [63:0]     base_r;
  logic [63:0]     offset_r;

  // Buffer state
  logic [63:0]     seen_r;
  logic [7:0]      passed_r;
  logic            reported_r;

  // Evaluation stage
  logic              s1_valid_r;
  logic              s1_last_r;
  logic              s1_elig_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [63:0]       s1_start_r;
  logic [63:0]       s1_base_off_r;

  // Output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [63:0]       out_addr_r;

  logic              in_acc;
  logic [LEN_W-1:0]  len_clamp;
  logic              elig;
  pat_cfg_t          cell_cfg;
  logic [7:0]        chain [MAX_PATTERN_BYTES+1];
  logic [MAX_PATTERN_BYTES-1:0] cell_hit;
  logic              hit;
  logic              emit_found;
  logic              emit_nf;
  logic              need_out;
  logic              out_free;
  logic              retire;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      wild_r     <= '0;
      len_r      <= '0;
      occ_r      <= '0;
      base_r     <= '0;
      offset_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        REG_PAT_HIGH: pat_high_r <= cfg_wdata;
        REG_WILD:     wild_r     <= cfg_wdata[31:0];
        REG_LEN:      len_r      <= cfg_wdata[4:0];
        REG_OCC:      occ_r      <= cfg_wdata[7:0];
        REG_BASE:     base_r     <= cfg_wdata;
        REG_OFFSET:   offset_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign len_clamp = (len_r > 5'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES)
                                                     : LEN_W'(len_r);

  // Enough bytes of this buffer for a full window
  assign elig = (len_clamp != '0) &&
                ((|seen_r[63:IDX_W]) ||
                 ({1'b0, seen_r[IDX_W-1:0]} >= (len_clamp - LEN_W'(1))));

  assign in_acc = in_tvalid && in_tready;

  // Byte counter and evaluation stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        seen_r <= in_tlast ? 64'd0 : seen_r + 64'd1;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (retire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r     <= in_tlast;
      s1_elig_r     <= elig;
      s1_len_r      <= len_clamp;
      s1_start_r    <= seen_r - 64'(len_clamp - LEN_W'(1));
      s1_base_off_r <= base_r + offset_r;
    end
  end

  // Window cell chain
  assign cell_cfg.pattern   = {pat_high_r, pat_low_r};
  assign cell_cfg.wildcards = wild_r;
  assign cell_cfg.len       = s1_len_r;
  assign chain[0]           = in_tdata[7:0];

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .byte_in  (chain[k]),
      .cell_idx (IDX_W'(k)),
      .cfg      (cell_cfg),
      .byte_out (chain[k+1]),
      .hit      (cell_hit[k])
    );
  end

  // Match decision
  assign hit        = s1_elig_r && (&cell_hit);
  assign emit_found = hit && !reported_r && (passed_r == occ_r);
  assign emit_nf    = s1_last_r && !reported_r && !emit_found;
  assign need_out   = emit_found || emit_nf;
  assign out_free   = !out_valid_r || out_tready;
  assign retire     = s1_valid_r && (!need_out || out_free);
  assign in_tready  = !s1_valid_r || retire;

  // Occurrence tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passed_r   <= '0;
      reported_r <= 1'b0;
    end else if (retire) begin
      if (s1_last_r) begin
        passed_r   <= '0;
        reported_r <= 1'b0;
      end else if (emit_found) begin
        reported_r <= 1'b1;
      end else if (hit && !reported_r) begin
        passed_r <= passed_r + 8'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire && need_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && need_out) begin
      out_found_r <= emit_found;
      out_addr_r  <= emit_found ? (s1_start_r + s1_base_off_r) : 64'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_addr_r;

endmodule

[rtl/wbps_checker.sv]
// Port-level checks for the scanner, bound to the top level.
module wbps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wbps_pkg::ADDR_W-1:0]     out_tdata,
  input logic                            out_tuser
);
  import wbps_pkg::*;

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat pending right after reset");

  // A not-found beat carries a zero address
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("not-found beat with nonzero address");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result beat changed");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[test/tb.sv]
// Self-checking testbench for the wildcard byte pattern scanner.
module tb;
  import wbps_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] data_byte
  logic                  in_tlast = 1'b0; // last_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [ADDR_W-1:0]     out_tdata;       // [63:0] match_address
  logic                  out_tuser;       // [0] found
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  wildcard_byte_pattern_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the configuration registers
  logic [63:0] pat_low_r = '0;
  logic [63:0] pat_high_r = '0;
  logic [31:0] wild_r = '0;
  logic [4:0]  len_r = '0;
  logic [7:0]  occ_r = '0;
  logic [63:0] base_r = '0;
  logic [63:0] offset_r = '0;

  // Shadow scan state
  logic [7:0]  win [MAX_PATTERN_BYTES];   // [0] = newest byte
  logic [63:0] seen_cnt = '0;
  logic [7:0]  skipped_cnt = '0;
  bit          buf_reported = 1'b0;

  scan_result_t due_results[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_closed = 0;
  int unsigned setups_used = 0;
  int unsigned hits_seen = 0;
  int unsigned misses_seen = 0;

  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int unsigned hold_req = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) win[k] = '0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
  endfunction

  function automatic int unsigned eff_len();
    return (len_r > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : len_r;
  endfunction

  // Predict the result (if any) of one accepted byte
  task automatic scan_predict(input logic [7:0] d, input logic l);
    logic [127:0] pat;
    logic [7:0]   pb, wb;
    int unsigned  n, i, k;
    bit           hit;
    scan_result_t r;
    pat = {pat_high_r, pat_low_r};
    n = eff_len();
    for (k = MAX_PATTERN_BYTES - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = d;
    if (!buf_reported && n != 0 && seen_cnt >= 64'(n - 1)) begin
      hit = 1'b1;
      for (i = 0; i < n; i++) begin
        pb = pat[8*i +: 8];
        wb = win[n-1-i];
        if (!wild_r[2*i] && wb[7:4] != pb[7:4]) hit = 1'b0;
        if (!wild_r[2*i+1] && wb[3:0] != pb[3:0]) hit = 1'b0;
      end
      if (hit) begin
        if (skipped_cnt == occ_r) begin
          r.found = 1'b1;
          r.addr = base_r + (seen_cnt + 64'd1 - 64'(n)) + offset_r;
          due_results.insert(due_results.size(), r);
          buf_reported = 1'b1;
        end else begin
          skipped_cnt = skipped_cnt + 8'd1;
        end
      end
    end
    seen_cnt = seen_cnt + 64'd1;
    // buffer end: not-found result, then fresh buffer state
    if (l) begin
      if (!buf_reported) begin
        r.found = 1'b0;
        r.addr = '0;
        due_results.insert(due_results.size(), r);
      end
      for (k = 0; k < MAX_PATTERN_BYTES; k++) win[k] = '0;
      seen_cnt = '0;
      skipped_cnt = '0;
      buf_reported = 1'b0;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    scan_result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat found=%0b addr=%h", out_tuser, out_tdata));
      end else begin
        r = due_results.pop_front();
        if (out_tuser !== r.found)
          report_mismatch($sformatf("found expected %0b got %0b", r.found, out_tuser));
        if (out_tdata !== r.addr)
          report_mismatch($sformatf("match_address expected %h got %h", r.addr, out_tdata));
        if (r.found) hits_seen++;
        else misses_seen++;
      end
    end
  end

  // Receiver: random stall bursts plus requested long hold-offs
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one byte, wait for the beat, then maybe pause
  task automatic send_byte(input logic [7:0] d, input logic l);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    scan_predict(d, l);
    bytes_sent++;
    if (l) buffers_closed++;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop sending and let every outstanding result arrive
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_PAT_LOW:  pat_low_r = val;
      REG_PAT_HIGH: pat_high_r = val;
      REG_WILD:     wild_r = val[31:0];
      REG_LEN:      len_r = val[4:0];
      REG_OCC:      occ_r = val[7:0];
      REG_BASE:     base_r = val;
      REG_OFFSET:   offset_r = val;
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [31:0] wild, input logic [4:0] len,
                            input logic [7:0] occ, input logic [63:0] base,
                            input logic [63:0] off);
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_WILD, {32'd0, wild});
    write_reg(REG_LEN, {59'd0, len});
    write_reg(REG_OCC, {56'd0, occ});
    write_reg(REG_BASE, base);
    write_reg(REG_OFFSET, off);
    cfg_we <= 1'b0;
    setups_used++;
  endtask

  // A byte that fits pattern position i, wildcard nibbles randomized
  function automatic logic [7:0] pattern_like(input int unsigned i);
    logic [127:0] pat;
    logic [7:0]   b;
    pat = {pat_high_r, pat_low_r};
    b = pat[8*i +: 8];
    if (wild_r[2*i]) b[7:4] = 4'($urandom_range(0, 15));
    if (wild_r[2*i+1]) b[3:0] = 4'($urandom_range(0, 15));
    return b;
  endfunction

  // Narrow alphabet makes repeats and overlaps likely
  function automatic logic [7:0] filler_byte(input bit narrow);
    logic [7:0] alpha [4];
    alpha[0] = 8'h00;
    alpha[1] = 8'hFF;
    alpha[2] = 8'hA5;
    alpha[3] = 8'h5A;
    return narrow ? alpha[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] pick_word(input bit narrow);
    logic [63:0] w;
    int unsigned k;
    for (k = 0; k < 8; k++) w[8*k +: 8] = filler_byte(narrow);
    return w;
  endfunction

  function automatic logic [63:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // Reset values: zero length, so each buffer ends not found
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();
  endtask

  // Overlapping matches with high-nibble wildcards; second match wanted,
  // address wraps past 2^64
  task automatic test_overlap_wildcard();
    load_setup(64'h0A0A, 64'h0, 32'h5, 5'd2, 8'd1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h5);
    send_byte(8'h1A, 1'b0);
    send_byte(8'h2A, 1'b0);
    send_byte(8'h3A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b1);
    drain_results();
  endtask

  // Buffer shorter than the pattern, then a match completed on the last byte
  task automatic test_short_buffer();
    load_setup(64'h00FF80, 64'h0, 32'h0, 5'd3, 8'd0, 64'h0, 64'h0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_results();
  endtask

  // Length above the maximum acts as 16; all-wildcard pattern
  task automatic test_length_clamp();
    int unsigned k;
    load_setup('1, '1, '1, 5'd31, 8'd0, 64'h1000, '1);
    for (k = 0; k < MAX_PATTERN_BYTES; k++)
      send_byte(8'($urandom_range(0, 255)), k == MAX_PATTERN_BYTES - 1);
    drain_results();
  endtask

  // One result per byte while the receiver holds off: input must back up
  task automatic test_backpressure();
    int unsigned k;
    src_idle_en = 1'b0;
    load_setup(pick_word(1'b0), pick_word(1'b0), 32'h3, 5'd1, 8'd0, pick_addr(), pick_addr());
    hold_req = 150;
    for (k = 0; k < 48; k++) send_byte(8'($urandom_range(0, 255)), 1'b1);
    drain_results();
    src_idle_en = 1'b1;
  endtask

  // One random setup followed by buffers seeded with pattern copies
  task automatic run_random_phase(input int unsigned n_items, input bit src_idle,
                                  input bit sink_idle);
    logic [31:0] wild;
    logic [4:0]  len;
    logic [7:0]  occ, b;
    bit          narrow, cut, l;
    int unsigned sent, blen, plen, copy_pos, k, r;
    drain_results();
    narrow = $urandom_range(0, 1);
    r = $urandom_range(0, 19);
    if (r == 0) len = 5'd0;
    else if (r == 1) len = 5'd16;
    else if (r == 2) len = 5'($urandom_range(17, 31));
    else if (r < 6) len = 5'($urandom_range(5, 15));
    else len = 5'($urandom_range(1, 4));
    r = $urandom_range(0, 5);
    if (r == 0) wild = '1;
    else if (r < 3) wild = $urandom;
    else wild = $urandom & $urandom & $urandom;
    r = $urandom_range(0, 9);
    if (r == 0) occ = 8'hFF;
    else if (r == 1) occ = 8'($urandom_range(0, 255));
    else occ = 8'($urandom_range(0, 3));
    load_setup(pick_word(narrow), pick_word(narrow), wild, len, occ, pick_addr(), pick_addr());
    src_idle_en = src_idle;
    sink_idle_en = sink_idle;
    plen = eff_len();
    cut = ($urandom_range(0, 2) == 0);
    sent = 0;
    while (sent < n_items) begin
      blen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                         : $urandom_range(1, 2 * plen + 6);
      copy_pos = plen;
      for (k = 0; k < blen; k++) begin
        // start a pattern copy now and then, sometimes over a running one
        if ((copy_pos >= plen && $urandom_range(0, 3) == 0) ||
            (copy_pos < plen && $urandom_range(0, 15) == 0))
          copy_pos = 0;
        if (copy_pos < plen) begin
          b = pattern_like(copy_pos);
          copy_pos++;
        end else begin
          b = filler_byte(narrow);
        end
        sent++;
        // leave the buffer open across the next setup change
        if (sent >= n_items && cut) begin
          send_byte(b, 1'b0);
          break;
        end
        l = (k == blen - 1);
        send_byte(b, l);
      end
    end
  endtask

  task automatic test_random_setups();
    int unsigned p;
    for (p = 0; p < 14; p++) run_random_phase(100, (p % 3) != 2, (p % 4) != 3);
  endtask

  // Closing stretch with both sides always ready
  task automatic test_quiet_tail();
    run_random_phase(100, 1'b0, 1'b0);
    run_random_phase(100, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_overlap_wildcard();
    test_short_buffer();
    test_length_clamp();
    test_backpressure();
    test_random_setups();
    test_quiet_tail();
    drain_results();
    repeat (8) @(posedge clk);
    $display("scanned %0d bytes in %0d closed buffers over %0d register setups",
             bytes_sent, buffers_closed, setups_used);
    $display("results checked: %0d matches, %0d buffers without the wanted match",
             hits_seen, misses_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/wbps_pkg.sv
rtl/wbps_cell.sv
rtl/wildcard_byte_pattern_scanner.sv
rtl/wbps_checker.sv
test/tb.sv
